// ===== rtl/ppm_frame_generator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ppm frame generator assertion macros
// shared concurrent assertion forms, sampled on i_clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_GENERATOR_UNIT_DEFINES_SVH
`define PPM_FRAME_GENERATOR_UNIT_DEFINES_SVH

// condition holds at every edge
`define PPMFG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle
`define PPMFG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the next cycle
`define PPMFG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ppmfg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm frame generator package
// request and result types, register codes and reset values
// ----------------------------------------------------------------------------
package ppmfg_pkg;

    localparam int MaxChannels = 16;
    localparam int ChanAddrW   = 5;
    localparam int SumW        = 20;

    localparam logic [1:0] CfgNumChannels = 2'd0;
    localparam logic [1:0] CfgFrameLen    = 2'd1;
    localparam logic [1:0] CfgPulseLen    = 2'd2;
    localparam logic [1:0] CfgActiveLevel = 2'd3;

    localparam logic ActTick  = 1'b0;
    localparam logic ActWrite = 1'b1;

    localparam logic [4:0]  RstNumChannels = 5'd8;
    localparam logic [15:0] RstFrameLen    = 16'd22500;
    localparam logic [11:0] RstPulseLen    = 12'd300;
    localparam logic        RstActiveLevel = 1'b0;
    localparam logic [15:0] RstChanWidth   = 16'd1500;
    localparam logic [15:0] RstIdle        = 16'd50;

    typedef struct packed {
        logic        action;
        logic [3:0]  channel_id;
        logic [15:0] channel_width;
    } t_ppm_req;

    typedef struct packed {
        logic ppm_level;
        logic write_error;
        logic frame_start;
    } t_ppm_rsp;

    typedef struct packed {
        logic                 we;
        logic [ChanAddrW-1:0] addr;
        logic [15:0]          data;
    } t_store_wr;

    function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [15:0] b);
        logic [SumW:0] s;
        s = {1'b0, a} + {{(SumW - 15){1'b0}}, b};
        return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
    endfunction

endpackage

// ===== rtl/ppmfg_chan_store.sv =====
// ----------------------------------------------------------------------------
// ppm frame generator channel width store
// one register per channel, loaded with the default width at reset
// ----------------------------------------------------------------------------
module ppmfg_chan_store #(
    parameter int MAX_CHANNELS = ppmfg_pkg::MaxChannels,
    localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppmfg_pkg::t_store_wr i_wr,
    input  logic [IdxW-1:0]      i_rd_addr,
    output logic [15:0]          o_rd_data
);

    logic [15:0] r_width [MAX_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_width[i] <= ppmfg_pkg::RstChanWidth;
            end
        end else if (i_wr.we) begin
            r_width[i_wr.addr[IdxW-1:0]] <= i_wr.data;
        end
    end

    assign o_rd_data = r_width[i_rd_addr];

endmodule

// ===== rtl/ppm_frame_generator_unit.sv =====
// a request is held in an input register, and its result is registered in an output register
// throughput: one request per cycle while the output is not stalled; a tick reads at most one store entry
// results wait in an output register while the next request is taken
// reset: synchronous, active low; registers other than the request and result data return to defaults at once,
// the channel store loads 1500 in the same cycle, no clearing pass
// ----------------------------------------------------------------------------
// ppm frame generator unit
// pulse-position frame sequencer driven by microsecond ticks and width writes
// ----------------------------------------------------------------------------
`include "ppm_frame_generator_unit_defines.svh"

module ppm_frame_generator_unit #(
    parameter int MAX_CHANNELS = ppmfg_pkg::MaxChannels
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ppmfg_pkg::t_ppm_req i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppmfg_pkg::t_ppm_rsp o_out_rsp
);

    localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CntW = $clog2(MAX_CHANNELS + 1);
    localparam int SumW = ppmfg_pkg::SumW;

    // configuration registers
    logic [4:0]  r_num_ch;
    logic [15:0] r_frame_len;
    logic [11:0] r_pulse_len;
    logic        r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch    <= ppmfg_pkg::RstNumChannels;
            r_frame_len <= ppmfg_pkg::RstFrameLen;
            r_pulse_len <= ppmfg_pkg::RstPulseLen;
            r_active    <= ppmfg_pkg::RstActiveLevel;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppmfg_pkg::CfgNumChannels: r_num_ch    <= i_cfg_data[4:0];
                ppmfg_pkg::CfgFrameLen:    r_frame_len <= i_cfg_data;
                ppmfg_pkg::CfgPulseLen:    r_pulse_len <= i_cfg_data[11:0];
                ppmfg_pkg::CfgActiveLevel: r_active    <= i_cfg_data[0];
            endcase
        end
    end

    // input and output registers
    logic                r_in_valid;
    ppmfg_pkg::t_ppm_req r_in_req;
    logic                r_out_valid;
    ppmfg_pkg::t_ppm_rsp r_out_rsp;
    logic                w_adv;
    logic                w_fire;
    logic                w_accept;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_adv;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // sequencer state
    logic            r_pulse_next;
    logic [CntW-1:0] r_chan_idx;
    logic [SumW-1:0] r_sum;
    logic [15:0]     r_countdown;
    logic            r_level;

    logic            n_pulse_next;
    logic [CntW-1:0] n_chan_idx;
    logic [SumW-1:0] n_sum;
    logic [15:0]     n_countdown;
    logic            n_level;
    ppmfg_pkg::t_ppm_rsp  n_rsp;
    ppmfg_pkg::t_store_wr w_wr;

    logic [5:0]      w_eff_cnt;
    logic            w_id_ok;
    logic            w_last;
    logic [15:0]     w_rd_width;
    logic [SumW-1:0] w_sum_pulse;
    logic [SumW-1:0] w_sum_width;
    logic [15:0]     w_pulse_ext;

    assign w_eff_cnt   = ({1'b0, r_num_ch} > 6'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS)
                                                               : {1'b0, r_num_ch};
    assign w_id_ok     = 6'(r_in_req.channel_id) < w_eff_cnt;
    assign w_last      = 6'(r_chan_idx) >= w_eff_cnt;
    assign w_pulse_ext = 16'(r_pulse_len);
    assign w_sum_pulse = ppmfg_pkg::sat_add(r_sum, w_pulse_ext);
    assign w_sum_width = ppmfg_pkg::sat_add(r_sum, w_rd_width);

    ppmfg_chan_store #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (r_chan_idx[IdxW-1:0]),
        .o_rd_data (w_rd_width)
    );

    always_comb begin
        n_pulse_next = r_pulse_next;
        n_chan_idx   = r_chan_idx;
        n_sum        = r_sum;
        n_countdown  = r_countdown;
        n_level      = r_level;
        n_rsp        = '0;
        w_wr.we      = 1'b0;
        w_wr.addr    = {1'b0, r_in_req.channel_id};
        w_wr.data    = r_in_req.channel_width;
        priority if (r_in_req.action == ppmfg_pkg::ActWrite) begin
            if (w_id_ok) begin
                w_wr.we = w_fire;
            end else begin
                n_rsp.write_error = 1'b1;
            end
        end else if (r_countdown > 16'd1) begin
            n_countdown = r_countdown - 16'd1;
        end else if (r_pulse_next) begin
            n_level           = r_active;
            n_countdown       = (r_pulse_len == '0) ? 16'd1 : w_pulse_ext;
            n_pulse_next      = 1'b0;
            n_rsp.frame_start = (r_chan_idx == '0);
        end else begin
            n_level      = ~r_active;
            n_pulse_next = 1'b1;
            if (w_last) begin
                // sync gap fills the frame
                n_countdown = ({4'd0, r_frame_len} > w_sum_pulse)
                            ? r_frame_len - w_sum_pulse[15:0] : 16'd1;
                n_chan_idx  = '0;
                n_sum       = '0;
            end else begin
                n_countdown = (w_rd_width > w_pulse_ext)
                            ? w_rd_width - w_pulse_ext : 16'd1;
                n_sum       = w_sum_width;
                n_chan_idx  = r_chan_idx + CntW'(1);
            end
        end
        n_rsp.ppm_level = n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pulse_next <= 1'b1;
            r_chan_idx   <= '0;
            r_sum        <= '0;
            r_countdown  <= ppmfg_pkg::RstIdle;
            r_level      <= ~ppmfg_pkg::RstActiveLevel;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid  <= 1'b1;
                r_pulse_next <= n_pulse_next;
                r_chan_idx   <= n_chan_idx;
                r_sum        <= n_sum;
                r_countdown  <= n_countdown;
                r_level      <= n_level;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_req <= i_in_req;
        end
        if (w_fire) begin
            r_out_rsp <= n_rsp;
        end
    end

    `PPMFG_ASSERT_ALWAYS(a_countdown_nonzero, r_countdown != 16'd0,
        "countdown reached zero")
    `PPMFG_ASSERT_ALWAYS(a_chan_idx_range, 6'(r_chan_idx) <= 6'(MAX_CHANNELS),
        "channel index out of range")
    `PPMFG_ASSERT_IMP(a_start_level, o_out_valid && o_out_rsp.frame_start,
        o_out_rsp.ppm_level == r_active && !o_out_rsp.write_error,
        "frame start at wrong level")
    `PPMFG_ASSERT_NEXT(a_tick_decrement,
        w_fire && r_in_req.action == ppmfg_pkg::ActTick && r_countdown > 16'd1,
        r_countdown == $past(r_countdown) - 16'd1 && r_level == $past(r_level),
        "tick did not count down")

endmodule

// ===== tb/tb_ppm_frame_generator_unit.sv =====
// ----------------------------------------------------------------------------
// ppm frame generator unit testbench
// drives microsecond ticks and channel width writes through the request port,
// predicts pin level, write errors and frame starts in step with the block,
// and compares every result, with both sides idling in random bursts in most tests
// ----------------------------------------------------------------------------
module tb_ppm_frame_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxChannels = ppmfg_pkg::MaxChannels;
    localparam int SumW        = ppmfg_pkg::SumW;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [1:0]          i_cfg_index = ppmfg_pkg::CfgNumChannels;
    logic [15:0]         i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    ppmfg_pkg::t_ppm_req i_in_req    = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    ppmfg_pkg::t_ppm_rsp o_out_rsp;

    ppm_frame_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // frame state as the block should hold it
    logic [4:0]      cfg_nch;
    logic [15:0]     cfg_frame;
    logic [11:0]     cfg_pulse;
    logic            cfg_active;
    logic [15:0]     chan_width [MaxChannels];
    logic            pulse_due;
    logic [4:0]      chan_idx;
    logic [SumW-1:0] frame_sum;
    logic [15:0]     phase_left;
    logic            pin_level;

    ppmfg_pkg::t_ppm_rsp ppm_out_q[$];
    ppmfg_pkg::t_ppm_rsp want_rsp;
    bit       idle_en = 1'b1;
    int       stall_left = 0;
    int       err_cnt = 0;
    int       n_ticks = 0;
    int       n_writes = 0;
    int       n_rejects = 0;
    int       n_frames = 0;
    int       n_settings = 0;

    task automatic flag_mismatch(string msg);
        err_cnt++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic reset_frame_model();
        cfg_nch    = ppmfg_pkg::RstNumChannels;
        cfg_frame  = ppmfg_pkg::RstFrameLen;
        cfg_pulse  = ppmfg_pkg::RstPulseLen;
        cfg_active = ppmfg_pkg::RstActiveLevel;
        for (int i = 0; i < MaxChannels; i++) begin
            chan_width[i] = ppmfg_pkg::RstChanWidth;
        end
        pulse_due  = 1'b1;
        chan_idx   = '0;
        frame_sum  = '0;
        phase_left = ppmfg_pkg::RstIdle;
        pin_level  = ~ppmfg_pkg::RstActiveLevel;
    endtask

    function automatic logic [4:0] live_channels();
        return (cfg_nch > 5'(MaxChannels)) ? 5'(MaxChannels) : cfg_nch;
    endfunction

    function automatic logic [15:0] gap_us(int unsigned total, int unsigned spent);
        return (total <= spent) ? 16'd1 : 16'(total - spent);
    endfunction

    function automatic logic [SumW-1:0] sum_plus(logic [SumW-1:0] acc, int unsigned v);
        int unsigned s;
        s = acc + v;
        return (s > (1 << SumW) - 1) ? '1 : SumW'(s);
    endfunction

    function automatic ppmfg_pkg::t_ppm_rsp step_frame(ppmfg_pkg::t_ppm_req r);
        ppmfg_pkg::t_ppm_rsp rsp;
        logic [4:0]          live;
        rsp  = '0;
        live = live_channels();
        if (r.action == ppmfg_pkg::ActWrite) begin
            if ({1'b0, r.channel_id} < live) begin
                chan_width[r.channel_id] = r.channel_width;
            end else begin
                rsp.write_error = 1'b1;
            end
        end else if (phase_left > 16'd1) begin
            phase_left = phase_left - 16'd1;
        end else if (pulse_due) begin
            pin_level  = cfg_active;
            phase_left = (cfg_pulse == '0) ? 16'd1 : {4'd0, cfg_pulse};
            pulse_due  = 1'b0;
            rsp.frame_start = (chan_idx == '0);
        end else begin
            pin_level = ~cfg_active;
            pulse_due = 1'b1;
            if (chan_idx >= live) begin
                frame_sum  = sum_plus(frame_sum, cfg_pulse);
                phase_left = gap_us(cfg_frame, frame_sum);
                chan_idx   = '0;
                frame_sum  = '0;
            end else begin
                phase_left = gap_us(chan_width[chan_idx[3:0]], cfg_pulse);
                frame_sum  = sum_plus(frame_sum, chan_width[chan_idx[3:0]]);
                chan_idx   = chan_idx + 5'd1;
            end
        end
        rsp.ppm_level = pin_level;
        return rsp;
    endfunction

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (!idle_en) begin
            stall_left  <= 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 11) == 0) begin
            stall_left  <= $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ppm_out_q.size() == 0) begin
                flag_mismatch("result with no request pending");
            end else begin
                want_rsp = ppm_out_q.pop_front();
                if (o_out_rsp.ppm_level !== want_rsp.ppm_level) begin
                    flag_mismatch($sformatf("ppm_level %b, expected %b",
                        o_out_rsp.ppm_level, want_rsp.ppm_level));
                end
                if (o_out_rsp.write_error !== want_rsp.write_error) begin
                    flag_mismatch($sformatf("write_error %b, expected %b",
                        o_out_rsp.write_error, want_rsp.write_error));
                end
                if (o_out_rsp.frame_start !== want_rsp.frame_start) begin
                    flag_mismatch($sformatf("frame_start %b, expected %b",
                        o_out_rsp.frame_start, want_rsp.frame_start));
                end
                if (want_rsp.frame_start) begin
                    n_frames++;
                end
            end
        end
    end

    task automatic send_req(ppmfg_pkg::t_ppm_req r);
        ppmfg_pkg::t_ppm_rsp rsp;
        if (idle_en && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rsp = step_frame(r);
        ppm_out_q.push_back(rsp);
        if (r.action == ppmfg_pkg::ActWrite) begin
            n_writes++;
            if (rsp.write_error) begin
                n_rejects++;
            end
        end else begin
            n_ticks++;
        end
    endtask

    task automatic run_ticks(int n);
        repeat (n) begin
            send_req('{action: ppmfg_pkg::ActTick, channel_id: 4'($urandom),
                       channel_width: 16'($urandom)});
        end
    endtask

    task automatic write_width(logic [3:0] id, logic [15:0] w);
        send_req('{action: ppmfg_pkg::ActWrite, channel_id: id, channel_width: w});
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (ppm_out_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            ppmfg_pkg::CfgNumChannels: cfg_nch    = data[4:0];
            ppmfg_pkg::CfgFrameLen:    cfg_frame  = data;
            ppmfg_pkg::CfgPulseLen:    cfg_pulse  = data[11:0];
            ppmfg_pkg::CfgActiveLevel: cfg_active = data[0];
            default: ;
        endcase
        n_settings++;
    endtask

    // reset defaults: 50 us idle, then the first pulse of a frame
    task automatic test_reset_state();
        run_ticks(52);
    endtask

    task automatic test_width_writes();
        wait_idle();
        program_reg(ppmfg_pkg::CfgPulseLen, 16'd6);
        program_reg(ppmfg_pkg::CfgFrameLen, 16'd120);
        write_width(4'd0, 16'd0);
        write_width(4'd7, 16'hFFFF);
        write_width(4'd7, 16'd20);
        write_width(4'd8, 16'hFFFF);
        write_width(4'd15, 16'd0);
        for (int i = 1; i < 7; i++) begin
            write_width(4'(i), 16'($urandom_range(0, 30)));
        end
        run_ticks(300);
    endtask

    task automatic test_count_limits();
        wait_idle();
        program_reg(ppmfg_pkg::CfgNumChannels, 16'hFFE0);
        write_width(4'd0, 16'd12);
        run_ticks(100);
        wait_idle();
        program_reg(ppmfg_pkg::CfgNumChannels, 16'hFFFF);
        for (int i = 0; i < MaxChannels; i++) begin
            write_width(4'(i), 16'($urandom_range(0, 30)));
        end
        run_ticks(150);
    endtask

    // channel and sync gaps that would drop below one microsecond
    task automatic test_gap_floor();
        wait_idle();
        program_reg(ppmfg_pkg::CfgNumChannels, 16'd2);
        program_reg(ppmfg_pkg::CfgPulseLen, 16'd20);
        program_reg(ppmfg_pkg::CfgFrameLen, 16'd30);
        write_width(4'd0, 16'd5);
        write_width(4'd1, 16'd20);
        run_ticks(200);
    endtask

    task automatic test_zero_pulse();
        wait_idle();
        program_reg(ppmfg_pkg::CfgPulseLen, 16'hF000);
        program_reg(ppmfg_pkg::CfgNumChannels, 16'd3);
        program_reg(ppmfg_pkg::CfgFrameLen, 16'd0);
        write_width(4'd2, 16'd3);
        run_ticks(120);
    endtask

    // level flips only take effect at the next phase change
    task automatic test_level_swap();
        wait_idle();
        program_reg(ppmfg_pkg::CfgActiveLevel, 16'hFFFF);
        run_ticks(25);
        wait_idle();
        program_reg(ppmfg_pkg::CfgActiveLevel, 16'hFFFE);
        run_ticks(25);
        wait_idle();
        program_reg(ppmfg_pkg::CfgActiveLevel, 16'd1);
        run_ticks(25);
    endtask

    task automatic test_random_frames();
        ppmfg_pkg::t_ppm_req r;
        logic [4:0]          nch;
        logic [4:0]          odd_counts [3];
        odd_counts = '{5'd0, 5'd16, 5'd31};
        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            idle_en = (ph % 4 != 3);
            nch = ($urandom_range(0, 4) == 0) ? odd_counts[$urandom_range(0, 2)]
                                               : 5'($urandom_range(1, 16));
            program_reg(ppmfg_pkg::CfgNumChannels, {11'($urandom), nch});
            program_reg(ppmfg_pkg::CfgFrameLen, ($urandom_range(0, 9) == 0) ?
                16'd1000 : 16'($urandom_range(0, 300)));
            program_reg(ppmfg_pkg::CfgPulseLen,
                {4'($urandom), 12'($urandom_range(0, 10))});
            program_reg(ppmfg_pkg::CfgActiveLevel, 16'($urandom));
            repeat (55) begin
                r.action        = ($urandom_range(0, 4) == 0) ? ppmfg_pkg::ActWrite
                                                               : ppmfg_pkg::ActTick;
                r.channel_id    = 4'($urandom);
                r.channel_width = 16'($urandom_range(0, 30));
                // full-range widths only where they are never stored
                if (r.action == ppmfg_pkg::ActTick ||
                    {1'b0, r.channel_id} >= live_channels()) begin
                    if ($urandom_range(0, 3) == 0) begin
                        r.channel_width = 16'($urandom);
                    end
                end
                send_req(r);
            end
        end
    endtask

    task automatic test_long_pulse();
        wait_idle();
        idle_en = 1'b0;
        program_reg(ppmfg_pkg::CfgNumChannels, 16'd1);
        program_reg(ppmfg_pkg::CfgPulseLen, 16'hFFFF);
        program_reg(ppmfg_pkg::CfgFrameLen, 16'd0);
        write_width(4'd0, 16'd0);
        run_ticks(80);
    endtask

    task automatic test_long_frame();
        wait_idle();
        program_reg(ppmfg_pkg::CfgPulseLen, 16'd1);
        program_reg(ppmfg_pkg::CfgFrameLen, 16'hFFFF);
        write_width(4'd0, 16'd1);
        run_ticks(80);
    endtask

    initial begin
        reset_frame_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_width_writes();
        test_count_limits();
        test_gap_floor();
        test_zero_pulse();
        test_level_swap();
        test_random_frames();
        test_long_pulse();
        test_long_frame();
        wait_idle();
        $display("ran %0d ticks and %0d width writes (%0d rejected)",
                 n_ticks, n_writes, n_rejects);
        $display("saw %0d frame starts over %0d register settings", n_frames, n_settings);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results pending", ppm_out_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ppmfg_pkg.sv
rtl/ppmfg_chan_store.sv
rtl/ppm_frame_generator_unit.sv
tb/tb_ppm_frame_generator_unit.sv
